// File: hdl/qrm_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants for the quaternion to rotation matrix unit
// no dependencies

package qrm_pkg;

  localparam int IN_W      = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W     = 16;
  localparam int NUM_ENT   = 9;

  // products, sum of squares, signed numerators, quotient register
  localparam int PROD_W = 2 * IN_W;
  localparam int S_W    = 2 * IN_W + 1;
  localparam int NUM_W  = S_W + 1;
  localparam int Q_W    = FRAC_BITS + 2;

  // restoring steps: one integer bit then the fraction bits
  localparam int DIV_STEPS = FRAC_BITS + 1;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [IN_W-1:0] z;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic           neg;
    logic [S_W-1:0] rem;
    logic [Q_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_ENT-1:0] lanes;
    logic  [S_W-1:0]     den;
    logic                zero;
  } div_stage_t;

  typedef struct packed {
    logic signed [NUM_ENT-1:0][OUT_W-1:0] ent;
    logic                                 zero;
  } result_t;

endpackage

// File: hdl/qrm_numer.sv
`timescale 1ns / 1ps
// front end: products, sum of squares, numerators and magnitudes (three stages)
// depends on qrm_pkg

module qrm_numer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qrm_pkg::quat_t      quat_i,
  output logic                valid_o,
  output qrm_pkg::div_stage_t stage_o
);

  // product order: ww xx yy zz xy wz wy xz yz wx
  logic signed [9:0][qrm_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                                   zero1_d, zero1_q, v1_q;

  logic        [qrm_pkg::S_W-1:0]                         s_d, s_q;
  logic signed [qrm_pkg::NUM_ENT-1:0][qrm_pkg::NUM_W-1:0] num_d, num_q;
  logic                                                   zero2_q, v2_q;

  qrm_pkg::div_stage_t stage_d, stage_q;
  logic                v3_q;

  logic signed [qrm_pkg::NUM_W-1:0] e [10];

  always_comb begin
    prod_d[0] = quat_i.w * quat_i.w;
    prod_d[1] = quat_i.x * quat_i.x;
    prod_d[2] = quat_i.y * quat_i.y;
    prod_d[3] = quat_i.z * quat_i.z;
    prod_d[4] = quat_i.x * quat_i.y;
    prod_d[5] = quat_i.w * quat_i.z;
    prod_d[6] = quat_i.w * quat_i.y;
    prod_d[7] = quat_i.x * quat_i.z;
    prod_d[8] = quat_i.y * quat_i.z;
    prod_d[9] = quat_i.w * quat_i.x;
    zero1_d   = (quat_i == '0);
  end

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      e[i] = qrm_pkg::NUM_W'($signed(prod_q[i]));
    end
    s_d = qrm_pkg::S_W'($unsigned(prod_q[0])) + qrm_pkg::S_W'($unsigned(prod_q[1]))
        + qrm_pkg::S_W'($unsigned(prod_q[2])) + qrm_pkg::S_W'($unsigned(prod_q[3]));
    num_d[0] = e[0] + e[1] - e[2] - e[3];
    num_d[1] = (e[4] - e[5]) <<< 1;
    num_d[2] = (e[6] + e[7]) <<< 1;
    num_d[3] = (e[4] + e[5]) <<< 1;
    num_d[4] = e[0] + e[2] - e[1] - e[3];
    num_d[5] = (e[8] - e[9]) <<< 1;
    num_d[6] = (e[7] - e[6]) <<< 1;
    num_d[7] = (e[8] + e[9]) <<< 1;
    num_d[8] = e[0] + e[3] - e[1] - e[2];
  end

  // magnitude never exceeds the sum of squares
  always_comb begin
    stage_d.den  = s_q;
    stage_d.zero = zero2_q;
    for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
      stage_d.lanes[k].neg = num_q[k][qrm_pkg::NUM_W-1];
      stage_d.lanes[k].rem = num_q[k][qrm_pkg::NUM_W-1] ?
                             qrm_pkg::S_W'(-num_q[k]) : qrm_pkg::S_W'(num_q[k]);
      stage_d.lanes[k].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      zero1_q <= zero1_d;
      s_q     <= s_d;
      num_q   <= num_d;
      zero2_q <= zero1_q;
      stage_q <= stage_d;
    end
  end

  assign valid_o = v3_q;
  assign stage_o = stage_q;

endmodule

// File: hdl/qrm_div_step.sv
`timescale 1ns / 1ps
// one registered restoring division step for all nine entries
// depends on qrm_pkg

module qrm_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                shift_i,
  input  logic                valid_i,
  input  qrm_pkg::div_stage_t stage_i,
  output logic                valid_o,
  output qrm_pkg::div_stage_t stage_o
);

  qrm_pkg::div_stage_t stage_d, stage_q;
  logic                valid_q;
  logic [qrm_pkg::S_W:0] trial [qrm_pkg::NUM_ENT];
  logic                  ge    [qrm_pkg::NUM_ENT];

  always_comb begin
    stage_d = stage_i;
    for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
      trial[k] = shift_i ? {stage_i.lanes[k].rem, 1'b0} : {1'b0, stage_i.lanes[k].rem};
      ge[k]    = (trial[k] >= {1'b0, stage_i.den});
      stage_d.lanes[k].rem = ge[k] ? qrm_pkg::S_W'(trial[k] - {1'b0, stage_i.den})
                                   : qrm_pkg::S_W'(trial[k]);
      stage_d.lanes[k].quo = {stage_i.lanes[k].quo[qrm_pkg::Q_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// File: hdl/qrm_finish.sv
`timescale 1ns / 1ps
// rounding, clamping, sign and zero-quaternion identity into the output register
// depends on qrm_pkg

module qrm_finish (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qrm_pkg::div_stage_t stage_i,
  output logic                valid_o,
  output qrm_pkg::result_t    result_o
);

  qrm_pkg::result_t     result_d, result_q;
  logic                 valid_q;
  logic [qrm_pkg::Q_W-1:0] q [qrm_pkg::NUM_ENT];

  always_comb begin
    result_d.zero = stage_i.zero;
    for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
      // half or more of the divisor left over rounds up
      q[k] = stage_i.lanes[k].quo
           + qrm_pkg::Q_W'({stage_i.lanes[k].rem, 1'b0} >= {1'b0, stage_i.den});
      if (q[k] > qrm_pkg::ONE_Q) begin
        q[k] = qrm_pkg::ONE_Q;
      end
      if (stage_i.zero) begin
        result_d.ent[k] = (k % 4 == 0) ? qrm_pkg::OUT_W'(qrm_pkg::ONE_Q) : '0;
      end else if (stage_i.lanes[k].neg) begin
        result_d.ent[k] = qrm_pkg::OUT_W'(-q[k]);
      end else begin
        result_d.ent[k] = qrm_pkg::OUT_W'(q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: hdl/quaternion_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// top level of the quaternion to rotation matrix unit
// depends on qrm_pkg, qrm_numer, qrm_div_step, qrm_finish

// Converts one quaternion (w, x, y, z), signed 16-bit at any common scale, into
// the nine entries of its normalized rotation matrix in signed Q2.14 (16384 is
// one), each rounded to nearest with ties away from zero and clamped to +-16384.
// An all-zero quaternion gives the identity and sets the tuser flag. One
// quaternion is taken per cycle unless a result waits at the output; the result
// shows on the output at the end of nineteen register stages: three front-end
// stages (products, sums, magnitudes), fifteen one-bit restoring division stages
// shared by all nine entries, and the rounding stage that is also the output
// register. The whole pipeline advances together and holds while a waiting
// result is not taken.

module quaternion_to_rotation_matrix_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic         m_axis_tuser    // zero_input
);

  logic                en;
  qrm_pkg::quat_t      quat;
  qrm_pkg::result_t    result;
  logic                out_valid;

  logic                div_valid [qrm_pkg::DIV_STEPS+1];
  qrm_pkg::div_stage_t div_stage [qrm_pkg::DIV_STEPS+1];

  // pipeline moves unless a finished result is stalled at the output
  assign en            = !(out_valid && !m_axis_tready);
  assign s_axis_tready = en;

  assign quat = s_axis_tdata;

  qrm_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .quat_i  (quat),
    .valid_o (div_valid[0]),
    .stage_o (div_stage[0])
  );

  // first step yields the integer bit, the rest the fraction bits
  for (genvar g = 0; g < qrm_pkg::DIV_STEPS; g++) begin : g_div
    qrm_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (g != 0),
      .valid_i (div_valid[g]),
      .stage_i (div_stage[g]),
      .valid_o (div_valid[g+1]),
      .stage_o (div_stage[g+1])
    );
  end

  qrm_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_valid[qrm_pkg::DIV_STEPS]),
    .stage_i  (div_stage[qrm_pkg::DIV_STEPS]),
    .valid_o  (out_valid),
    .result_o (result)
  );

  // entry 0 (r00) in the lowest bits
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = result.ent;
  assign m_axis_tuser  = result.zero;

`ifndef SYNTHESIS
  a_zero_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[15:0] == 16'd16384 && m_axis_tdata[79:64] == 16'd16384 &&
       m_axis_tdata[143:128] == 16'd16384 && m_axis_tdata[63:16] == '0 &&
       m_axis_tdata[127:80] == '0))
    else $error("zero quaternion did not give identity");

  a_r00_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384))
    else $error("r00 outside clamp range");

  a_stall_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");
`endif

endmodule

// File: tb/tb_quaternion_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// self-checking bench for the quaternion to rotation matrix unit
// depends on qrm_pkg and the unit; a local fixed-point predictor gives expected matrices

module tb_quaternion_to_rotation_matrix_unit;

  localparam int LATENCY   = 19;
  localparam int N_RANDOM  = 1300;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    logic [qrm_pkg::OUT_W-1:0] ent [qrm_pkg::NUM_ENT];
    logic                      zero;
  } matrix_t;

  typedef struct {
    logic signed [qrm_pkg::IN_W-1:0] w, x, y, z;
    logic                            has_fixed;   // expected result typed into the table
    logic                            fixed_zero;
  } quat_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;   // quat_w, quat_x, quat_y, quat_z
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  logic         m_axis_tuser;   // zero_input

  matrix_t     matrix_q [$];
  int          n_errors;
  int          n_matrices;
  int          n_zero_seen;
  int          cycles;
  logic        stall_mode;

  quaternion_to_rotation_matrix_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // round(num * 2^FRAC_BITS / den), ties away from zero, clamped to one
  function automatic logic [qrm_pkg::OUT_W-1:0] scaled_entry(longint num,
                                                             longint unsigned den);
    logic            neg;
    longint unsigned rem;
    longint unsigned quo;
    longint          res;
    neg = num < 0;
    rem = neg ? longint'(-num) : num;
    quo = rem / den;
    rem = rem % den;
    if (quo > 1) quo = 2;
    for (int i = 0; i < qrm_pkg::FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem -= den;
        quo |= 1;
      end
    end
    if (rem >= den - rem) quo++;
    if (quo > (64'd1 << qrm_pkg::FRAC_BITS)) quo = 64'd1 << qrm_pkg::FRAC_BITS;
    res = neg ? -longint'(quo) : longint'(quo);
    return res[qrm_pkg::OUT_W-1:0];
  endfunction

  function automatic matrix_t rotation_of(logic signed [qrm_pkg::IN_W-1:0] qw, qx, qy, qz);
    matrix_t         m;
    longint          w, x, y, z, ww, xx, yy, zz;
    longint unsigned s;
    w = qw; x = qx; y = qy; z = qz;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    s = ww + xx + yy + zz;
    if (s == 0) begin
      foreach (m.ent[k]) begin
        m.ent[k] = (k % 4 == 0) ? qrm_pkg::OUT_W'(1 << qrm_pkg::FRAC_BITS) : '0;
      end
      m.zero = 1'b1;
    end else begin
      m.ent[0] = scaled_entry(ww + xx - yy - zz, s);
      m.ent[1] = scaled_entry(2 * (x * y - w * z), s);
      m.ent[2] = scaled_entry(2 * (w * y + x * z), s);
      m.ent[3] = scaled_entry(2 * (x * y + w * z), s);
      m.ent[4] = scaled_entry(ww + yy - xx - zz, s);
      m.ent[5] = scaled_entry(2 * (y * z - w * x), s);
      m.ent[6] = scaled_entry(2 * (x * z - w * y), s);
      m.ent[7] = scaled_entry(2 * (y * z + w * x), s);
      m.ent[8] = scaled_entry(ww + zz - xx - yy, s);
      m.zero   = 1'b0;
    end
    return m;
  endfunction

  // directed rows: zero, axis extremes, full-scale mixes, tiny and rounding cases
  localparam int N_DIRECTED = 20;
  quat_row_t directed_rows [N_DIRECTED];
  initial begin
    directed_rows[0]  = '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b1};
    directed_rows[1]  = '{16'sd32767,  16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b0};
    directed_rows[2]  = '{-16'sd32768, 16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b0};
    directed_rows[3]  = '{16'sd0,      16'sd32767,  16'sd0,      16'sd0,      1'b0, 1'b0};
    directed_rows[4]  = '{16'sd0,      16'sd0,      -16'sd32768, 16'sd0,      1'b0, 1'b0};
    directed_rows[5]  = '{16'sd0,      16'sd0,      16'sd0,      -16'sd32768, 1'b0, 1'b0};
    directed_rows[6]  = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0};
    directed_rows[7]  = '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 1'b0};
    directed_rows[8]  = '{16'sd32767,  -16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, 1'b0};
    directed_rows[9]  = '{16'sd1,      16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b0};
    directed_rows[10] = '{16'sd0,      16'sd0,      16'sd0,      16'sd1,      1'b0, 1'b0};
    directed_rows[11] = '{16'sd1,      16'sd1,      16'sd1,      16'sd1,      1'b0, 1'b0};
    directed_rows[12] = '{-16'sd1,     16'sd1,      -16'sd1,     16'sd1,      1'b0, 1'b0};
    directed_rows[13] = '{16'sd1,      16'sd1,      16'sd0,      16'sd0,      1'b0, 1'b0};
    directed_rows[14] = '{16'sd1,      16'sd2,      16'sd3,      16'sd4,      1'b0, 1'b0};
    directed_rows[15] = '{16'sd3,      16'sd0,      16'sd0,      16'sd4,      1'b0, 1'b0};
    directed_rows[16] = '{16'sd32767,  16'sd1,      16'sd0,      16'sd0,      1'b0, 1'b0};
    directed_rows[17] = '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b1};
    directed_rows[18] = '{16'sd5,      -16'sd7,     16'sd11,     -16'sd13,    1'b0, 1'b0};
    directed_rows[19] = '{-16'sd21846, 16'sd21845,  16'sd10922,  -16'sd10923, 1'b0, 1'b0};
  end

  // typed expectation: identity for the zero and pure-scalar rows
  function automatic matrix_t identity_result(logic zero_flag);
    matrix_t m;
    foreach (m.ent[k]) begin
      m.ent[k] = (k % 4 == 0) ? qrm_pkg::OUT_W'(1 << qrm_pkg::FRAC_BITS) : '0;
    end
    m.zero = zero_flag;
    return m;
  endfunction

  // one transfer on the slave side; gap handling is left to the caller
  task automatic send_quat(logic signed [qrm_pkg::IN_W-1:0] qw, qx, qy, qz, matrix_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qz, qy, qx, qw};
    do @(posedge clk_i); while (!s_axis_tready);
    matrix_q.push_back(want);
  endtask

  task automatic idle_cycles(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [qrm_pkg::IN_W-1:0] random_component();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return qrm_pkg::IN_W'($urandom_range(0, 6)) - 16'sd3;
      3:       return qrm_pkg::IN_W'($urandom_range(0, 255)) - 16'sd128;
      default: return qrm_pkg::IN_W'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int burst;
    logic signed [qrm_pkg::IN_W-1:0] qw, qx, qy, qz;
    matrix_t want;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      qw = directed_rows[i].w; qx = directed_rows[i].x;
      qy = directed_rows[i].y; qz = directed_rows[i].z;
      want = directed_rows[i].has_fixed ? identity_result(directed_rows[i].fixed_zero)
                                        : rotation_of(qw, qx, qy, qz);
      send_quat(qw, qx, qy, qz, want);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
    end

    // drain completely once so the pipeline is seen empty and refilled
    s_axis_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        if ($urandom_range(0, 49) == 0) begin
          qw = 0; qx = 0; qy = 0; qz = 0;
        end else begin
          qw = random_component(); qx = random_component();
          qy = random_component(); qz = random_component();
        end
        send_quat(qw, qx, qy, qz, rotation_of(qw, qx, qy, qz));
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    s_axis_tvalid <= 1'b0;
  end

  // receiver: alternates between free-running and random stalls
  initial begin
    m_axis_tready = 1'b0;
    stall_mode    = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  // checker on each master-side transfer
  always @(posedge clk_i) begin
    matrix_t want;
    logic [qrm_pkg::OUT_W-1:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        $error("unexpected matrix transfer: data %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = matrix_q.pop_front();
        n_matrices++;
        if (m_axis_tuser) n_zero_seen++;
        for (int k = 0; k < qrm_pkg::NUM_ENT; k++) begin
          got = m_axis_tdata[k*qrm_pkg::OUT_W +: qrm_pkg::OUT_W];
          if (got !== want.ent[k]) begin
            $error("r%0d%0d mismatch: expected %0d actual %0d", k / 3, k % 3,
                   $signed(want.ent[k]), $signed(got));
            n_errors++;
          end
        end
        if (m_axis_tuser !== want.zero) begin
          $error("zero_input mismatch: expected %0b actual %0b", want.zero, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    n_errors    = 0;
    n_matrices  = 0;
    n_zero_seen = 0;
    cycles      = 0;
    fork
      begin
        wait (rst_ni === 1'b1);
        repeat (N_DIRECTED + N_RANDOM) begin
          do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
        end
        // one more edge so the last expectation is queued before the drain check
        @(posedge clk_i);
        while (matrix_q.size() != 0) @(posedge clk_i);
        repeat (2 * LATENCY) @(posedge clk_i);
      end
      begin
        while (cycles < CYCLE_CAP) begin
          @(posedge clk_i);
          cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    join_any
    $display("checked %0d matrices (%0d zero quaternions) from %0d directed and %0d random",
             n_matrices, n_zero_seen, N_DIRECTED, N_RANDOM);
    $display("quaternions under bursty input and stalled output, %0d cycles", cycles);
    if (n_errors == 0 && matrix_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
